@@ hw/rtl/oaht_pkg.sv @@
// Shared types and codes for the open-addressing hash table core.
`default_nettype none

package oaht_pkg;

    // Request modes
    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_SET    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SCAN   = 2'd3
    } mode_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_RO   = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Load limit after reset
    localparam logic [7:0] MAX_ENTRIES_RESET = 8'd192;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Slot key word: key 0 means no key
    typedef struct packed {
        logic        tomb;
        logic [31:0] key;
    } meta_t;

    // Slot payload word
    typedef struct packed {
        logic        ro;
        logic [63:0] value;
    } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/open_addressing_hash_table_core.sv @@
// Open-addressing hash table with linear probing, tombstones and a forward scan.
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid, in_ready, mode, key_id, key_hash,         | request in
//          | value_in, read_only, start_index                    |
//  out     | out_valid, out_ready, hit, value_out, key_out,      | result out
//          | next_index, status                                  |
//  cfg     | cfg_valid, cfg_ready, cfg_data (max_entries)        | write in
//
// Each request walks the slot memories one slot per cycle through a single read
// port: a get, set or delete walks its probe chain, a scan walks forward to an
// occupied slot, and a request settled without a probe goes straight to done.
// After reset a clearing pass empties the key memory while in_ready stays low;
// cfg_ready is always high. A result waits in the output register while the
// next request is taken; a new result stalls until it drains.
`default_nettype none

module open_addressing_hash_table_core
    import oaht_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] key_id,
    input  wire logic [31:0] key_hash,
    input  wire logic [63:0] value_in,
    input  wire logic        read_only,
    input  wire logic [8:0]  start_index,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [63:0]      value_out,
    output logic [31:0]      key_out,
    output logic [8:0]       next_index,
    output logic [1:0]       status,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int AW = $clog2(CAPACITY);

    // Slot memories
    meta_t  meta_mem  [CAPACITY];
    entry_t entry_mem [CAPACITY];

    // Control registers
    state_t          state_reg, state_next;
    logic [7:0]      max_reg;
    logic [8:0]      count_reg, count_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            tomb_seen_reg, tomb_seen_next;
    logic            out_valid_reg, out_valid_next;

    // Request and datapath registers
    mode_t           op_reg, op_next;
    logic [31:0]     key_reg, key_next;
    logic [63:0]     val_reg, val_next;
    logic            ro_reg, ro_next;
    logic [AW-1:0]   chk_idx_reg, chk_idx_next;
    logic [AW-1:0]   tomb_idx_reg, tomb_idx_next;
    meta_t           meta_rd_reg;
    entry_t          entry_rd_reg;
    logic            res_hit_reg, res_hit_next;
    logic [63:0]     res_value_reg, res_value_next;
    logic [31:0]     res_key_reg, res_key_next;
    logic [8:0]      res_next_reg, res_next_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            out_hit_reg, out_hit_next;
    logic [63:0]     out_value_reg, out_value_next;
    logic [31:0]     out_key_reg, out_key_next;
    logic [8:0]      out_next_reg, out_next_next;
    logic [1:0]      out_status_reg, out_status_next;

    // Memory port controls
    logic [AW-1:0]   rd_addr;
    logic            meta_we;
    logic [AW-1:0]   meta_waddr;
    meta_t           meta_wdata;
    logic            entry_we;
    logic [AW-1:0]   entry_waddr;
    entry_t          entry_wdata;

    // Evaluation of the slot just read
    logic            in_fire;
    logic            out_free;
    logic [31:0]     start_w;
    logic            imm_done;
    logic            is_empty;
    logic            is_tomb;
    logic            is_match;
    logic            probe_last;
    logic            probe_done;
    logic            scan_done;
    logic [31:0]     slot_plus_one;
    logic            found;
    logic            is_new;
    logic            grows;
    logic [AW-1:0]   slot_idx;
    logic            over_limit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign start_w   = 32'(start_index);

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign value_out  = out_value_reg;
    assign key_out    = out_key_reg;
    assign next_index = out_next_reg;
    assign status     = out_status_reg;

    // Classify the request and the slot that came back from memory
    always_comb
    begin
        is_empty      = (meta_rd_reg.key == 32'd0) && !meta_rd_reg.tomb;
        is_tomb       = (meta_rd_reg.key == 32'd0) && meta_rd_reg.tomb;
        is_match      = (meta_rd_reg.key == key_reg);
        probe_last    = (cnt_reg == {AW{1'b1}});
        probe_done    = is_empty || is_match || probe_last;
        scan_done     = (meta_rd_reg.key != 32'd0) || (chk_idx_reg == {AW{1'b1}});
        slot_plus_one = 32'(chk_idx_reg) + 32'd1;

        // Requests answered without touching the table
        imm_done = 1'b0;
        unique case (mode_t'(mode))
            MODE_GET, MODE_DELETE: imm_done = (key_id == 32'd0) || (count_reg == 9'd0);
            MODE_SET:              imm_done = (key_id == 32'd0);
            MODE_SCAN:             imm_done = (count_reg == 9'd0) ||
                                              (start_w >= 32'(CAPACITY));
        endcase

        // Where the probe lands
        priority if (is_match)
        begin
            found    = 1'b1;
            is_new   = 1'b0;
            grows    = 1'b0;
            slot_idx = chk_idx_reg;
        end
        else if (is_empty)
        begin
            found    = 1'b1;
            is_new   = 1'b1;
            grows    = !tomb_seen_reg;
            slot_idx = tomb_seen_reg ? tomb_idx_reg : chk_idx_reg;
        end
        else
        begin
            found    = tomb_seen_reg || is_tomb;
            is_new   = 1'b1;
            grows    = 1'b0;
            slot_idx = tomb_seen_reg ? tomb_idx_reg : chk_idx_reg;
        end

        over_limit = (10'(count_reg) + 10'd1) > 10'(max_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (imm_done)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (mode_t'(mode) == MODE_SCAN)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and results
    always_comb
    begin
        count_next      = count_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg + {{(AW-1){1'b0}}, 1'b1};
        tomb_seen_next  = tomb_seen_reg;
        tomb_idx_next   = tomb_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        ro_next         = ro_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        res_key_next    = res_key_reg;
        res_next_next   = res_next_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_hit_next    = out_hit_reg;
        out_value_next  = out_value_reg;
        out_key_next    = out_key_reg;
        out_next_next   = out_next_reg;
        out_status_next = out_status_reg;
        rd_addr         = chk_idx_reg + {{(AW-1){1'b0}}, 1'b1};
        meta_we         = 1'b0;
        meta_waddr      = slot_idx;
        meta_wdata      = '{tomb: 1'b0, key: key_reg};
        entry_we        = 1'b0;
        entry_waddr     = slot_idx;
        entry_wdata     = '{ro: ro_reg, value: val_reg};

        unique case (state_reg)
            // Sweep the key memory empty
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '{tomb: 1'b0, key: 32'd0};
                clr_next   = clr_reg + {{(AW-1){1'b0}}, 1'b1};
            end

            // Latch the request and issue the first read
            ST_IDLE:
            begin
                op_next         = mode_t'(mode);
                key_next        = key_id;
                val_next        = value_in;
                ro_next         = read_only;
                cnt_next        = '0;
                tomb_seen_next  = 1'b0;
                res_hit_next    = 1'b0;
                res_value_next  = 64'd0;
                res_key_next    = 32'd0;
                res_next_next   = 9'd0;
                res_status_next = STATUS_OK;
                if (mode_t'(mode) == MODE_SCAN)
                begin
                    rd_addr = start_w[AW-1:0];
                end
                else
                begin
                    rd_addr = key_hash[AW-1:0];
                end
            end

            // Walk the probe chain one slot per cycle
            ST_PROBE:
            begin
                if (is_tomb && !tomb_seen_reg)
                begin
                    tomb_seen_next = 1'b1;
                    tomb_idx_next  = chk_idx_reg;
                end
                if (probe_done)
                begin
                    unique case (op_reg)
                        MODE_GET:
                        begin
                            res_hit_next   = is_match;
                            res_value_next = is_match ? entry_rd_reg.value : 64'd0;
                        end
                        MODE_DELETE:
                        begin
                            res_hit_next = is_match;
                            meta_we      = is_match;
                            meta_waddr   = chk_idx_reg;
                            meta_wdata   = '{tomb: 1'b1, key: 32'd0};
                        end
                        MODE_SET:
                        begin
                            priority if (!found || (grows && over_limit))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                meta_we      = 1'b1;
                                entry_we     = 1'b1;
                                res_hit_next = is_new;
                                if (grows)
                                begin
                                    count_next = count_reg + 9'd1;
                                end
                                if (!is_new && entry_rd_reg.ro)
                                begin
                                    res_status_next = STATUS_RO;
                                end
                            end
                        end
                        MODE_SCAN:
                        begin
                            res_hit_next = 1'b0;
                        end
                    endcase
                end
            end

            // Walk forward to the next occupied slot
            ST_SCAN:
            begin
                if (meta_rd_reg.key != 32'd0)
                begin
                    res_hit_next   = 1'b1;
                    res_key_next   = meta_rd_reg.key;
                    res_value_next = entry_rd_reg.value;
                    res_next_next  = slot_plus_one[8:0];
                end
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_value_next  = res_value_reg;
                    out_key_next    = res_key_reg;
                    out_next_next   = res_next_reg;
                    out_status_next = res_status_reg;
                end
            end

            default:
            begin
                meta_we = 1'b0;
            end
        endcase

        chk_idx_next = rd_addr;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            max_reg       <= MAX_ENTRIES_RESET;
            count_reg     <= 9'd0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            tomb_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            tomb_seen_reg <= tomb_seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        ro_reg         <= ro_next;
        chk_idx_reg    <= chk_idx_next;
        tomb_idx_reg   <= tomb_idx_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        res_key_reg    <= res_key_next;
        res_next_reg   <= res_next_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_value_reg  <= out_value_next;
        out_key_reg    <= out_key_next;
        out_next_reg   <= out_next_next;
        out_status_reg <= out_status_next;
    end

    // Key memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[rd_addr];
    end

    // Value memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        entry_rd_reg <= entry_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ bench/oaht_table_checker.sv @@
// Checker for the hash table core: mirrors the slot table, predicts each result and compares.
module oaht_table_checker
    import oaht_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] key_id,
    input  logic [31:0] key_hash,
    input  logic [63:0] value_in,
    input  logic        read_only,
    input  logic [8:0]  start_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        hit,
    input  logic [63:0] value_out,
    input  logic [31:0] key_out,
    input  logic [8:0]  next_index,
    input  logic [1:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bit        hit;
        bit [63:0] value;
        bit [31:0] key;
        bit [8:0]  next;
        bit [1:0]  status;
    } table_result_t;

    // Mirror of the slot memories
    bit [31:0] slot_key   [SLOTS];
    bit [63:0] slot_value [SLOTS];
    bit        slot_ro    [SLOTS];
    bit        slot_tomb  [SLOTS];
    int        used_slots;
    bit [7:0]  load_limit;

    table_result_t due_results[$];

    // Walk the probe chain: stop at the key or an empty slot, prefer the first tombstone
    function automatic bit find_slot(input bit [31:0] key, input bit [31:0] hash,
                                     output int slot);
        int idx;
        int n;
        bit seen_tomb;
        int tomb;
        idx = int'(hash & 32'(SLOTS - 1));
        seen_tomb = 1'b0;
        tomb = 0;
        slot = 0;
        for (n = 0; n < SLOTS; n++)
        begin
            if (slot_key[idx] == 32'd0)
            begin
                if (!slot_tomb[idx])
                begin
                    slot = seen_tomb ? tomb : idx;
                    return 1'b1;
                end
                if (!seen_tomb)
                begin
                    seen_tomb = 1'b1;
                    tomb = idx;
                end
            end
            else if (slot_key[idx] == key)
            begin
                slot = idx;
                return 1'b1;
            end
            idx = (idx + 1) % SLOTS;
        end
        slot = tomb;
        return seen_tomb;
    endfunction

    // Apply one request to the mirror and return the result it produces
    function automatic table_result_t table_step(mode_t m, bit [31:0] key, bit [31:0] hash,
                                                 bit [63:0] val, bit ro, bit [8:0] start);
        table_result_t r;
        int s;
        int i;
        bit is_new;
        bit grows;
        r = '0;
        case (m)
            MODE_GET, MODE_DELETE:
            begin
                if (used_slots != 0 && key != 32'd0)
                begin
                    if (find_slot(key, hash, s))
                    begin
                        if (slot_key[s] == key)
                        begin
                            r.hit = 1'b1;
                            if (m == MODE_GET)
                                r.value = slot_value[s];
                            else
                            begin
                                slot_key[s] = 32'd0;
                                slot_tomb[s] = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_SET:
            begin
                if (key != 32'd0)
                begin
                    if (!find_slot(key, hash, s))
                        r.status = STATUS_FULL;
                    else
                    begin
                        is_new = (slot_key[s] == 32'd0);
                        grows = is_new && !slot_tomb[s];
                        if (grows && used_slots + 1 > int'(load_limit))
                            r.status = STATUS_FULL;
                        else
                        begin
                            if (grows)
                                used_slots = used_slots + 1;
                            else if (!is_new && slot_ro[s])
                                r.status = STATUS_RO;
                            slot_key[s] = key;
                            slot_tomb[s] = 1'b0;
                            slot_value[s] = val;
                            slot_ro[s] = ro;
                            r.hit = is_new;
                        end
                    end
                end
            end
            default:
            begin
                if (used_slots != 0 && start < SLOTS)
                begin
                    for (i = int'(start); i < SLOTS && !r.hit; i++)
                    begin
                        if (slot_key[i] != 32'd0)
                        begin
                            r.hit = 1'b1;
                            r.key = slot_key[i];
                            r.value = slot_value[i];
                            r.next = 9'(i + 1);
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    // Compare a drained result against the oldest prediction
    task automatic check_result();
        table_result_t want;
        if (due_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no request outstanding", $time);
            return;
        end
        want = due_results.pop_front();
        if (hit !== want.hit)
            note_mismatch("hit", 64'(want.hit), 64'(hit));
        if (value_out !== want.value)
            note_mismatch("value_out", want.value, value_out);
        if (key_out !== want.key)
            note_mismatch("key_out", 64'(want.key), 64'(key_out));
        if (next_index !== want.next)
            note_mismatch("next_index", 64'(want.next), 64'(next_index));
        if (status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(status));
    endtask

    task automatic clear_table();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_ro[i] = 1'b0;
            slot_tomb[i] = 1'b0;
        end
        used_slots = 0;
        load_limit = MAX_ENTRIES_RESET;
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    // Track handshakes: drain results first, then register writes, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            due_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                load_limit = cfg_data;
            if (in_valid && in_ready)
                due_results.push_back(table_step(mode_t'(mode), key_id, key_hash, value_in,
                                                 read_only, start_index));
            outstanding = due_results.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Top-level bench for the hash table core: clock, reset, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oaht_pkg::*;

    localparam int SLOTS = 256;
    localparam int POOL  = 48;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
    logic        read_only;
    logic [8:0]  start_index;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [63:0] value_out;
    logic [31:0] key_out;
    logic [8:0]  next_index;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int mismatches;
    int outstanding;
    int idle_odds;

    // Keys with fixed hashes packed into four clusters so probe chains collide
    bit [31:0] pool_key  [POOL];
    bit [31:0] pool_hash [POOL];

    open_addressing_hash_table_core #(.CAPACITY(SLOTS)) u_dut (
        .clk, .rst_n,
        .in_valid, .in_ready, .mode, .key_id, .key_hash, .value_in, .read_only, .start_index,
        .out_valid, .out_ready, .hit, .value_out, .key_out, .next_index, .status,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    oaht_table_checker #(.SLOTS(SLOTS)) u_table_check (
        .clk, .rst_n,
        .in_valid, .in_ready, .mode, .key_id, .key_hash, .value_in, .read_only, .start_index,
        .out_valid, .out_ready, .hit, .value_out, .key_out, .next_index, .status,
        .cfg_valid, .cfg_ready, .cfg_data,
        .mismatches, .outstanding
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up long after the slowest legal run
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Stall the result side in random bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Present one request, hold it until taken, then maybe idle
    task automatic send_request(mode_t m, bit [31:0] k, bit [31:0] h, bit [63:0] v, bit ro,
                                bit [8:0] s);
        in_valid <= 1'b1;
        mode <= m;
        key_id <= k;
        key_hash <= h;
        value_in <= v;
        read_only <= ro;
        start_index <= s;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    // Hold off requests until every result has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_limit(bit [7:0] limit);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic on pooled keys, some noise and stray hashes
    task automatic random_request();
        int r;
        int k;
        mode_t m;
        bit [31:0] key;
        bit [31:0] hash;
        bit [8:0] start;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, POOL - 1);
        start = 9'($urandom_range(0, SLOTS));
        if (r < 8)
        begin
            m = mode_t'($urandom_range(0, 3));
            key = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
            hash = $urandom;
            start = 9'($urandom);
        end
        else
        begin
            key = pool_key[k];
            hash = (r < 12) ? $urandom : pool_hash[k];
            r = $urandom_range(0, 99);
            if (r < 40)
                m = MODE_SET;
            else if (r < 65)
                m = MODE_GET;
            else if (r < 85)
                m = MODE_DELETE;
            else
                m = MODE_SCAN;
        end
        send_request(m, key, hash, {$urandom, $urandom}, 1'($urandom), start);
    endtask

    initial
    begin
        int i;
        bit [31:0] base [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_GET;
        key_id = '0;
        key_hash = '0;
        value_in = '0;
        read_only = 1'b0;
        start_index = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_odds = 3;

        // Build the key pool; one cluster sits at the top to force wrap-around
        base[0] = 32'd250;
        for (i = 1; i < 4; i++)
            base[i] = $urandom_range(0, SLOTS - 1);
        for (i = 0; i < POOL; i++)
        begin
            do pool_key[i] = $urandom; while (pool_key[i] == 32'd0);
            pool_hash[i] = ($urandom & 32'hFFFF_FF00)
                         | ((base[i % 4] + $urandom_range(0, 11)) % SLOTS);
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: load limit of one first
        write_limit(8'd1);
        send_request(MODE_GET,    32'd5, 32'd0, 64'd0, 1'b0, 9'd0);
        send_request(MODE_DELETE, 32'd5, 32'd0, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SET,    32'd0, 32'd0, 64'd1, 1'b0, 9'd0);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 1'b1, 9'd0);
        send_request(MODE_SET,    32'd7, 32'd0, 64'd2, 1'b0, 9'd0);
        send_request(MODE_GET,    32'd0, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_DELETE, 32'd0, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd255);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd256);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'h1FF);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd0);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd0);
        // Reuse the tombstone even at the load limit, then refuse a fresh slot
        send_request(MODE_SET, 32'd1, 32'h0000_00FF, 64'h8000_0000_0000_0001, 1'b0, 9'd0);
        send_request(MODE_SET, 32'd2, 32'h0000_00FF, 64'h1234_5678_9ABC_DEF0, 1'b0, 9'd0);

        // Widest load limit
        write_limit(8'd255);
        send_request(MODE_SET,    32'd2, 32'h0000_00FF, 64'h1234_5678_9ABC_DEF0, 1'b0, 9'd0);
        send_request(MODE_GET,    32'd2, 32'h0000_00FF, 64'd0, 1'b0, 9'd0);
        send_request(MODE_DELETE, 32'd9, 32'h0000_0010, 64'd0, 1'b0, 9'd0);
        send_request(MODE_SCAN,   32'd0, 32'd0, 64'd0, 1'b0, 9'd1);

        // Random traffic with a full drain partway through
        idle_odds = 4;
        for (i = 0; i < 300; i++)
        begin
            if (i == 150)
                drain();
            random_request();
        end

        // Tight limit below the current fill: only tombstones and existing keys get in
        write_limit(8'($urandom_range(8, 48)));
        idle_odds = 2;
        for (i = 0; i < 250; i++)
            random_request();

        // Back to the reset limit, no idling on either side
        write_limit(MAX_ENTRIES_RESET);
        idle_odds = 0;
        for (i = 0; i < 250; i++)
            random_request();

        drain();
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ open_addressing_hash_table_core.f @@
hw/rtl/oaht_pkg.sv
hw/rtl/open_addressing_hash_table_core.sv
bench/oaht_table_checker.sv
bench/tb_top.sv
